### rtl/tsrma_pkg.sv
package tsrma_pkg;

  // Fixed field widths of the sample and result words
  localparam int unsigned MINUTE_W = 16;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned FILL_W   = 5;

  // Default build values
  localparam int unsigned TICK_HZ_DEFAULT = 32768;
  localparam int unsigned WINDOW_DEFAULT  = 16;

  // Seconds per minute, and 0.5 expressed in Q16.16
  localparam int unsigned SECONDS_PER_MINUTE = 60;
  localparam int unsigned HALF_Q16           = 32768;

  // Action codes carried by the sample word
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Status of the shared divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/tsrma_if.sv
interface tsrma_in_if import tsrma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [MINUTE_W-1:0] minute;
  logic [TICK_W-1:0]   tick_count;

  modport source (output valid, action, minute, tick_count, input ready);
  modport sink   (input valid, action, minute, tick_count, output ready);
endinterface

interface tsrma_out_if import tsrma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] average_rate;
  logic [FILL_W-1:0] window_fill;
  logic              zero_interval;

  modport source (output valid, average_rate, window_fill, zero_interval, input ready);
  modport sink   (input valid, average_rate, window_fill, zero_interval, output ready);
endinterface

### rtl/tsrma_divider.sv
module tsrma_divider import tsrma_pkg::*; #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 37
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output div_stat_t     stat
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] div_r, div_nxt;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          take;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted   = {rem_r, quo_r[DW-1]};
    diff      = shifted - {1'b0, div_r};
    take      = (shifted >= {1'b0, div_r});
    count_nxt = count_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    if (start) begin
      count_nxt = CW'(DW);
      busy_nxt  = 1'b1;
      rem_nxt   = '0;
      quo_nxt   = dividend;
      div_nxt   = divisor;
    end else if (busy_r) begin
      rem_nxt   = take ? diff[VW-1:0] : shifted[VW-1:0];
      quo_nxt   = {quo_r[DW-2:0], take};
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### rtl/tsrma_ring_mem.sv
module tsrma_ring_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/timestamp_rate_moving_average.sv
// Timestamp rate meter with a moving average over the last WINDOW rates.
// in_ch (sink) takes one word per event: action, minute and tick_count.
// A restart word clears the history; a sample word forms the absolute tick
// minute*60*TICK_HZ + tick_count. The first sample after reset or restart
// is only recorded and yields no result; every later sample yields one
// word on out_ch: the mean rate in Q16.16, the number of rates averaged
// and a flag for a zero interval (rate saturated).
// A sample with a predecessor runs through two divisions on the single
// shared restoring divider, DW being its dividend width, one quotient bit
// a cycle: first TICK_HZ*32768/delta, then sum/fill. A zero or backward
// interval skips the first division.
// The stored rates sit in a small synchronous RAM read in the check state,
// ahead of the read-modify-write of the running sum.
// in_ch.ready is high only while no sample is in progress. A finished
// result waits in the output register while the next word is taken; if
// the receiver stalls, the following result waits until it is freed.
// Reset (rst_n low, synchronous) clears the history, the running sum and
// the output valid; the rate RAM needs no clearing.
module timestamp_rate_moving_average import tsrma_pkg::*; #(
  parameter int unsigned TICK_HZ = TICK_HZ_DEFAULT,
  parameter int unsigned WINDOW  = WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  tsrma_in_if.sink    in_ch,
  tsrma_out_if.source out_ch
);

  // Derived widths
  localparam longint unsigned TMAX =
    64'((1 << MINUTE_W) - 1) * SECONDS_PER_MINUTE * TICK_HZ + 64'((64'd1 << TICK_W) - 1);
  localparam int unsigned     TW      = $clog2(TMAX + 1);
  localparam longint unsigned NUM     = 64'(TICK_HZ) * HALF_Q16;
  localparam int unsigned     NW      = $clog2(NUM + 1);
  localparam int unsigned     SUM_W   = RATE_W + $clog2(WINDOW);
  localparam int unsigned     DW      = (NW > SUM_W) ? NW : SUM_W;
  localparam int unsigned     VW      = (TW > FILL_W) ? TW : FILL_W;
  localparam int unsigned     SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [TW-1:0]   MIN_TICKS = TW'(SECONDS_PER_MINUTE * TICK_HZ);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_CHECK,
    S_DIV_RATE,
    S_SUM,
    S_DIV_AVG,
    S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [TW-1:0]       now_r, now_nxt;
  logic [TW-1:0]       prev_r, prev_nxt;
  logic                prev_valid_r, prev_valid_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;
  logic                zero_r, zero_nxt;
  logic [RATE_W-1:0]   avg_r, avg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RATE_W-1:0]   out_rate_r, out_rate_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;
  logic                out_zero_r, out_zero_nxt;

  logic [TW:0]         delta;
  logic                full;
  logic [SUM_W:0]      sum_base;
  logic [SUM_W:0]      sum_new;
  logic                in_fire;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [VW-1:0]       div_divisor;
  logic [DW-1:0]       div_quotient;
  div_stat_t           div_stat;

  logic                mem_wr_en;
  logic                mem_rd_en;
  logic [RATE_W-1:0]   mem_rd_data;

  tsrma_divider #(
    .DW (DW),
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  tsrma_ring_mem #(
    .DEPTH (WINDOW),
    .AW    (SLOT_W),
    .DW    (RATE_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (slot_r),
    .wr_data (rate_r),
    .rd_en   (mem_rd_en),
    .rd_addr (slot_r),
    .rd_data (mem_rd_data)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Modular interval; a borrow means the timestamp went backwards
  assign delta    = {1'b0, now_r} - {1'b0, prev_r};
  assign full     = (fill_r == FILL_W'(WINDOW));
  // Drop the oldest rate when the window is full, then add the new one
  assign sum_base = {1'b0, sum_r} - (full ? (SUM_W + 1)'(mem_rd_data) : '0);
  assign sum_new  = sum_base + (SUM_W + 1)'(rate_r);

  always_comb begin
    state_nxt      = state_r;
    minute_nxt     = minute_r;
    ticks_nxt      = ticks_r;
    now_nxt        = now_r;
    prev_nxt       = prev_r;
    prev_valid_nxt = prev_valid_r;
    sum_nxt        = sum_r;
    fill_nxt       = fill_r;
    slot_nxt       = slot_r;
    rate_nxt       = rate_r;
    zero_nxt       = zero_r;
    avg_nxt        = avg_r;
    out_valid_nxt  = out_valid_r;
    out_rate_nxt   = out_rate_r;
    out_fill_nxt   = out_fill_r;
    out_zero_nxt   = out_zero_r;
    div_start      = 1'b0;
    div_dividend   = DW'(NUM);
    div_divisor    = VW'(delta[TW-1:0]);
    mem_wr_en      = 1'b0;
    mem_rd_en      = 1'b0;

    // Release the output word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == ACT_RESTART) begin
            prev_valid_nxt = 1'b0;
            sum_nxt        = '0;
            fill_nxt       = '0;
            slot_nxt       = '0;
          end else begin
            minute_nxt = in_ch.minute;
            ticks_nxt  = in_ch.tick_count;
            state_nxt  = S_TICK;
          end
        end
      end
      S_TICK: begin
        now_nxt   = TW'(TW'(minute_r) * MIN_TICKS) + TW'(ticks_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        prev_nxt       = now_r;
        prev_valid_nxt = 1'b1;
        if (!prev_valid_r) begin
          state_nxt = S_IDLE;
        end else begin
          // Fetch the oldest rate ahead of the sum update
          mem_rd_en = 1'b1;
          zero_nxt  = (delta == '0);
          if (delta == '0) begin
            rate_nxt  = '1;
            state_nxt = S_SUM;
          end else if (delta[TW]) begin
            rate_nxt  = '0;
            state_nxt = S_SUM;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV_RATE;
          end
        end
      end
      S_DIV_RATE: begin
        if (div_stat.done) begin
          if (div_quotient > DW'({RATE_W{1'b1}})) begin
            rate_nxt = '1;
          end else begin
            rate_nxt = div_quotient[RATE_W-1:0];
          end
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        mem_wr_en = 1'b1;
        sum_nxt   = sum_new[SUM_W-1:0];
        fill_nxt  = full ? fill_r : fill_r + FILL_W'(1);
        slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + SLOT_W'(1);
        div_start    = 1'b1;
        div_dividend = DW'(sum_nxt);
        div_divisor  = VW'(fill_nxt);
        state_nxt    = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (div_stat.done) begin
          avg_nxt   = div_quotient[RATE_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Load the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_rate_nxt  = avg_r;
          out_fill_nxt  = fill_r;
          out_zero_nxt  = zero_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      prev_r       <= '0;
      prev_valid_r <= 1'b0;
      sum_r        <= '0;
      fill_r       <= '0;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      prev_r       <= prev_nxt;
      prev_valid_r <= prev_valid_nxt;
      sum_r        <= sum_nxt;
      fill_r       <= fill_nxt;
      slot_r       <= slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    minute_r   <= minute_nxt;
    ticks_r    <= ticks_nxt;
    now_r      <= now_nxt;
    rate_r     <= rate_nxt;
    zero_r     <= zero_nxt;
    avg_r      <= avg_nxt;
    out_rate_r <= out_rate_nxt;
    out_fill_r <= out_fill_nxt;
    out_zero_r <= out_zero_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.average_rate  = out_rate_r;
  assign out_ch.window_fill   = out_fill_r;
  assign out_ch.zero_interval = out_zero_r;

`ifndef SYNTH
  // A restart word empties the window and forgets the last timestamp
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.action == ACT_RESTART) |=> (fill_r == '0) && !prev_valid_r)
    else $error("restart did not clear the history");

  // Stored rates imply a recorded timestamp
  a_fill_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> prev_valid_r)
    else $error("window holds rates without a previous timestamp");

  // The divider only runs while a division state waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV_RATE) || (state_r == S_DIV_AVG))
    else $error("divider busy outside a division state");

  // Every result word averages between one and WINDOW rates
  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fill_r != '0) && (out_fill_r <= FILL_W'(WINDOW)))
    else $error("result word carries an impossible window fill");
`endif

endmodule

### tb/timestamp_rate_moving_average_tb.sv
module timestamp_rate_moving_average_tb import tsrma_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Build values of the block under test
  localparam int unsigned TICK_HZ = TICK_HZ_DEFAULT;
  localparam int unsigned WINDOW  = WINDOW_DEFAULT;

  // Ticks in one minute, and the rate numerator: TICK_HZ/(2*delta) in Q16.16
  // is TICK_HZ*32768/delta, 32768 being one half in Q16.16
  localparam logic [63:0] TICKS_PER_MINUTE = 64'(SECONDS_PER_MINUTE) * 64'(TICK_HZ);
  localparam logic [63:0] RATE_NUMERATOR   = 64'(TICK_HZ) * 64'(HALF_Q16);
  localparam logic [63:0] TICK_FIELD_MAX   = 64'(32'hFFFF_FFFF);
  localparam logic [63:0] MINUTE_FIELD_MAX = 64'(16'hFFFF);
  localparam logic [63:0] STAMP_MAX        = MINUTE_FIELD_MAX * TICKS_PER_MINUTE + TICK_FIELD_MAX;
  localparam logic [RATE_W-1:0] RATE_SATURATED = '1;

  localparam int unsigned RANDOM_WORDS = 570;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PRINT_CAP     = 50;

  typedef struct packed {
    logic [RATE_W-1:0] average_rate;
    logic [FILL_W-1:0] window_fill;
    logic              zero_interval;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst_n;

  tsrma_in_if  in_ch ();
  tsrma_out_if out_ch ();

  timestamp_rate_moving_average #(
    .TICK_HZ (TICK_HZ),
    .WINDOW  (WINDOW)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // Shadow of the meter: last absolute tick, the ring of rates and its sum
  logic [63:0]       last_stamp;
  logic              last_stamp_valid = 1'b0;
  logic [RATE_W-1:0] rate_ring [WINDOW];
  logic [63:0]       rate_total = '0;
  int unsigned       ring_fill = 0;
  int unsigned       ring_slot = 0;

  // Averages still owed by the block, oldest first
  rate_result_t pending_averages [$];

  // Absolute tick of the last well-formed stamp sent
  logic [63:0] stream_stamp = '0;
  // Hold both sides free of idling while set
  logic        no_idle = 1'b0;

  int unsigned n_errors = 0;
  int unsigned n_samples = 0;
  int unsigned n_restarts = 0;
  int unsigned n_zero = 0;
  int unsigned n_backward = 0;
  int unsigned n_checked = 0;
  int unsigned deepest_fill = 0;
  int unsigned quiet_cycles = 0;

  // Print one mismatch line (up to a cap, to keep the log short) and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Advance the shadow meter by one accepted word; queue the average it owes
  task automatic meter_advance(input logic act, input logic [MINUTE_W-1:0] mn,
                               input logic [TICK_W-1:0] tk);
    logic [63:0]       stamp;
    logic [63:0]       delta;
    logic [63:0]       quot;
    logic [RATE_W-1:0] rate;
    logic              zero;
    rate_result_t      res;
    if (act == ACT_RESTART) begin
      // Drop the history; the ring contents become stale, never read again
      last_stamp_valid = 1'b0;
      rate_total = '0;
      ring_fill = 0;
      ring_slot = 0;
      n_restarts++;
      return;
    end
    n_samples++;
    stamp = 64'(mn) * TICKS_PER_MINUTE + 64'(tk);
    if (!last_stamp_valid) begin
      // First sample after reset or restart: record only
      last_stamp = stamp;
      last_stamp_valid = 1'b1;
      return;
    end
    // Modular difference: a backward step wraps to a huge delta, rate near 0
    delta = stamp - last_stamp;
    if (stamp < last_stamp)
      n_backward++;
    last_stamp = stamp;
    zero = (delta == '0);
    if (zero) begin
      rate = RATE_SATURATED;
      n_zero++;
    end else begin
      quot = RATE_NUMERATOR / delta;
      rate = (quot > 64'(RATE_SATURATED)) ? RATE_SATURATED : quot[RATE_W-1:0];
    end
    // Full window: evict the oldest rate from the sum before overwriting it
    if (ring_fill >= WINDOW)
      rate_total -= 64'(rate_ring[ring_slot]);
    else
      ring_fill++;
    rate_ring[ring_slot] = rate;
    rate_total += 64'(rate);
    ring_slot = (ring_slot + 1) % WINDOW;
    quot = rate_total / 64'(ring_fill);
    res.average_rate  = quot[RATE_W-1:0];
    res.window_fill   = FILL_W'(ring_fill);
    res.zero_interval = zero;
    pending_averages.push_back(res);
  endtask

  // Offer one word after a random gap and hold it until the block takes it.
  // Valid stays high after acceptance; the next call lowers it only if it
  // idles, so valid never sees two assignments in one step.
  task automatic send_word(input logic act, input logic [MINUTE_W-1:0] mn,
                           input logic [TICK_W-1:0] tk);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.minute     <= mn;
    in_ch.tick_count <= tk;
    do @(posedge clk); while (!in_ch.ready);
    meter_advance(act, mn, tk);
  endtask

  // Send an absolute tick as a sample word. Split it into minute and
  // tick_count, sometimes borrowing minutes into a large tick_count so the
  // upper counter bits get exercised.
  task automatic send_stamp(input logic [63:0] stamp);
    logic [63:0] mn;
    logic [63:0] tk;
    logic [63:0] headroom;
    logic [63:0] borrow;
    mn = stamp / TICKS_PER_MINUTE;
    if (mn > MINUTE_FIELD_MAX)
      mn = MINUTE_FIELD_MAX;
    tk = stamp - mn * TICKS_PER_MINUTE;
    headroom = (TICK_FIELD_MAX - tk) / TICKS_PER_MINUTE;
    borrow = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 2200))
                                         : 64'($urandom_range(0, 2));
    if (borrow > headroom) borrow = headroom;
    if (borrow > mn)       borrow = mn;
    mn -= borrow;
    tk = stamp - mn * TICKS_PER_MINUTE;
    stream_stamp = stamp;
    send_word(ACT_SAMPLE, mn[MINUTE_W-1:0], tk[TICK_W-1:0]);
  endtask

  // Hold the sender idle until every owed average has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_averages.size() != 0);
  endtask

  // Extremes of the fields, zero and backward intervals, double restart
  task automatic test_special_cases();
    send_word(ACT_SAMPLE, '0, '0);             // first sample: recorded only
    send_word(ACT_SAMPLE, '0, '0);             // zero interval, rate saturates
    send_word(ACT_SAMPLE, '0, 32'd1);          // one tick: highest finite rate
    send_word(ACT_SAMPLE, '1, '1);             // largest stamp the fields allow
    send_word(ACT_SAMPLE, '0, '0);             // backward step, rate 0
    send_word(ACT_RESTART, '1, '1);            // fields of a restart are ignored
    send_word(ACT_RESTART, '0, '0);            // restart on an empty history
    send_word(ACT_SAMPLE, '1, '0);             // first again after restart
    send_stamp(STAMP_MAX - 64'(TICK_HZ));      // just below the top
    send_stamp(STAMP_MAX);                     // one second later: rate 0.5
  endtask

  // Fill the ring past its depth with saturated and other high rates so
  // the sum needs more than 32 bits and the oldest entry gets evicted
  task automatic test_window_wrap();
    send_word(ACT_RESTART, '0, '0);
    send_stamp(64'($urandom_range(0, 1 << 20)));
    for (int i = 0; i <= WINDOW; i++) begin
      if (i % 3 == 0)
        send_stamp(stream_stamp);
      else
        send_stamp(stream_stamp + 64'($urandom_range(1, 8)));
    end
  endtask

  // Mostly well-formed stamp streams with random intervals, salted with
  // restarts, repeated stamps, backward steps and raw random words
  task automatic test_random_traffic();
    int unsigned pick;
    logic [63:0] delta;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // Switch idling off for some stretches
      if (i % 60 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      // Let the block run dry now and then, mid-stream
      if (i == 200 || i == 400)
        drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_word(ACT_RESTART, MINUTE_W'($urandom()), $urandom());
      end else if (pick < 8) begin
        send_word(ACT_SAMPLE, MINUTE_W'($urandom()), $urandom());
        stream_stamp = last_stamp;
      end else if (pick < 12) begin
        send_stamp(stream_stamp);
      end else if (pick < 15) begin
        delta = 64'($urandom_range(1, 1 << 20));
        send_stamp((stream_stamp > delta) ? stream_stamp - delta : '0);
      end else begin
        case ($urandom_range(0, 3))
          0:       delta = 64'($urandom_range(1, 64));
          1:       delta = 64'($urandom_range(1, 65535));
          2:       delta = 64'($urandom_range(1, 1 << 30));
          default: delta = {28'd0, 4'($urandom()), 32'($urandom())};
        endcase
        // Out of room at the top: start the stream again low down
        if (stream_stamp + delta > STAMP_MAX)
          send_stamp(64'($urandom_range(0, 1 << 16)));
        else
          send_stamp(stream_stamp + delta);
      end
    end
    no_idle = 1'b0;
  endtask

  // Take results with random stalls and compare each with the oldest owed
  initial begin : result_checker
    int unsigned  stall;
    rate_result_t want;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      if (pending_averages.size() == 0) begin
        report_mismatch("unowed result, average_rate", 64'(out_ch.average_rate), '0);
      end else begin
        want = pending_averages.pop_front();
        n_checked++;
        if (out_ch.average_rate !== want.average_rate)
          report_mismatch("average_rate", 64'(out_ch.average_rate),
                          64'(want.average_rate));
        if (out_ch.window_fill !== want.window_fill)
          report_mismatch("window_fill", 64'(out_ch.window_fill),
                          64'(want.window_fill));
        if (out_ch.zero_interval !== want.zero_interval)
          report_mismatch("zero_interval", 64'(out_ch.zero_interval),
                          64'(want.zero_interval));
        if (want.window_fill > deepest_fill)
          deepest_fill = 32'(want.window_fill);
      end
    end
  end

  // Abort the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_SAMPLE;
    in_ch.minute     <= '0;
    in_ch.tick_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_window_wrap();
    test_random_traffic();

    // Wait for the last averages, then give any stray word time to appear
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples and %0d restarts; checked %0d averages",
             n_samples, n_restarts, n_checked);
    $display("Saw %0d zero intervals, %0d backward steps, window filled to %0d of %0d",
             n_zero, n_backward, deepest_fill, WINDOW);
    if (n_errors == 0 && pending_averages.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### timestamp_rate_moving_average.f
rtl/tsrma_pkg.sv
rtl/tsrma_if.sv
rtl/tsrma_divider.sv
rtl/tsrma_ring_mem.sv
rtl/timestamp_rate_moving_average.sv
tb/timestamp_rate_moving_average_tb.sv
